FILE: hdl/irenc_pkg.sv
// Package for the pulse-width IR frame encoder.
// Holds the register index codes, reset values, sequencer phase codes and shared types.
// No dependencies.
package irenc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_ONE_TIME  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_ZERO_TIME = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIME       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_TIME      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAD_TIME      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_COUNT = 3'd5;

    localparam logic [7:0] RST_HIGH_ONE_TIME  = 8'd177;
    localparam logic [7:0] RST_HIGH_ZERO_TIME = 8'd137;
    localparam logic [7:0] RST_GAP_TIME       = 8'd70;
    localparam logic [7:0] RST_TAIL_TIME      = 8'd50;
    localparam logic [7:0] RST_LEAD_TIME      = 8'd20;
    localparam logic [3:0] RST_PREAMBLE_COUNT = 4'd15;

    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_BEGIN    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LEAD     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_PRE_HI   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PRE_LO   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_START_HI = 4'd4;
    localparam logic [PHASE_W-1:0] PH_START_LO = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BIT_HI   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_BIT_LO   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TAIL     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CLOSE    = 4'd9;

    typedef struct packed {
        logic [7:0] high_one_time;
        logic [7:0] high_zero_time;
        logic [7:0] gap_time;
        logic [7:0] tail_time;
        logic [7:0] lead_time;
        logic [3:0] preamble_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       open_frame;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_port_t;

endpackage

FILE: hdl/irenc_if.sv
// Handshake interfaces for the input and result channels of the IR frame encoder.
// Each carries valid, ready and the word payload; no dependencies.
interface irenc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface irenc_out_if;
    logic       valid;
    logic       ready;
    logic       level;
    logic [7:0] duration;
    logic       run_end;
    logic       frame_done;

    modport source (output valid, output level, output duration, output run_end,
                    output frame_done, input ready);
    modport sink   (input valid, input level, input duration, input run_end,
                    input frame_done, output ready);
endinterface

FILE: hdl/irenc_front.sv
// Front end of the IR frame encoder: accepts input words and marks frame openings.
// Depends on irenc_pkg and irenc_if.
module irenc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    irenc_in_if.sink             in_ch,
    input  logic                 queue_full,
    output irenc_pkg::queue_port_t push
);
    import irenc_pkg::*;

    logic in_frame_reg;
    logic in_frame_next;
    logic accept;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && !queue_full;

    always_comb
    begin
        push.valid            = accept;
        push.entry.data_byte  = in_ch.data_byte;
        push.entry.last_byte  = in_ch.last_byte;
        push.entry.open_frame = !in_frame_reg;
        in_frame_next         = accept ? !in_ch.last_byte : in_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

FILE: hdl/irenc_queue.sv
// Two-entry queue between the front end and the segment sequencer.
// Depends on irenc_pkg.
module irenc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irenc_pkg::queue_port_t push,
    output logic                   full,
    output irenc_pkg::queue_port_t head,
    input  logic                   pop
);
    import irenc_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full       = count_reg[1];
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/irenc_back.sv
// Back end of the IR frame encoder: steps through the segments of the head word
// and loads them into the result register. Depends on irenc_pkg and irenc_if.
module irenc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irenc_pkg::cfg_t        cfg,
    input  irenc_pkg::queue_port_t head,
    output logic                   pop,
    irenc_out_if.source            out_ch
);
    import irenc_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [3:0]         cnt_reg;
    logic [3:0]         cnt_next;
    logic [PHASE_W-1:0] cur_phase;
    logic [3:0]         cur_cnt;
    logic [3:0]         cnt_inc;
    logic               step;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       level_reg;
    logic       level_next;
    logic [7:0] duration_reg;
    logic [7:0] duration_next;
    logic       run_end_reg;
    logic       run_end_next;
    logic       frame_done_reg;
    logic       frame_done_next;

    assign step    = head.valid && (!out_valid_reg || out_ch.ready);
    assign cnt_inc = cur_cnt + 4'd1;

    always_comb
    begin
        if (phase_reg == PH_BEGIN)
        begin
            cur_phase = head.entry.open_frame ? PH_LEAD : PH_BIT_HI;
            cur_cnt   = 4'd0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_cnt   = cnt_reg;
        end
    end

    always_comb
    begin
        phase_next      = cur_phase;
        cnt_next        = cur_cnt;
        level_next      = 1'b0;
        duration_next   = cfg.gap_time;
        run_end_next    = 1'b0;
        frame_done_next = 1'b0;
        pop             = 1'b0;
        unique case (cur_phase)
            PH_LEAD:
            begin
                duration_next = cfg.lead_time;
                cnt_next      = 4'd0;
                phase_next    = (cfg.preamble_count != 4'd0) ? PH_PRE_HI : PH_START_HI;
            end
            PH_PRE_HI:
            begin
                level_next    = 1'b1;
                duration_next = cfg.high_zero_time;
                phase_next    = PH_PRE_LO;
            end
            PH_PRE_LO:
            begin
                cnt_next   = cnt_inc;
                phase_next = (cnt_inc == cfg.preamble_count) ? PH_START_HI : PH_PRE_HI;
            end
            PH_START_HI:
            begin
                level_next    = 1'b1;
                duration_next = cfg.high_one_time;
                phase_next    = PH_START_LO;
            end
            PH_START_LO:
            begin
                cnt_next   = 4'd0;
                phase_next = PH_BIT_HI;
            end
            PH_BIT_HI:
            begin
                level_next    = 1'b1;
                duration_next = head.entry.data_byte[cur_cnt[2:0]] ? cfg.high_one_time
                                                                   : cfg.high_zero_time;
                phase_next    = PH_BIT_LO;
            end
            PH_BIT_LO:
            begin
                cnt_next = cnt_inc;
                if (cur_cnt[2:0] != 3'd7)
                begin
                    phase_next = PH_BIT_HI;
                end
                else if (head.entry.last_byte)
                begin
                    phase_next = PH_TAIL;
                end
                else
                begin
                    phase_next   = PH_BEGIN;
                    run_end_next = 1'b1;
                    pop          = step;
                end
            end
            PH_TAIL:
            begin
                level_next    = 1'b1;
                duration_next = cfg.tail_time;
                phase_next    = PH_CLOSE;
            end
            PH_CLOSE:
            begin
                duration_next   = 8'd0;
                run_end_next    = 1'b1;
                frame_done_next = 1'b1;
                phase_next      = PH_BEGIN;
                pop             = step;
            end
            default:
            begin
                phase_next = PH_BEGIN;
            end
        endcase
        out_valid_next = step || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            level_reg      <= level_next;
            duration_reg   <= duration_next;
            run_end_reg    <= run_end_next;
            frame_done_reg <= frame_done_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.level      = level_reg;
    assign out_ch.duration   = duration_reg;
    assign out_ch.run_end    = run_end_reg;
    assign out_ch.frame_done = frame_done_reg;

endmodule

FILE: hdl/pulse_width_ir_frame_encoder_core.sv
// Top level of the pulse-width IR frame encoder: configuration registers, front end,
// word queue and segment sequencer. Depends on irenc_pkg, irenc_if, irenc_front,
// irenc_queue and irenc_back.
//
// Each input word yields a series of result words, one per clock while the result side
// takes them: sixteen for a byte inside a frame, 19 + 2 * preamble_count for the byte
// that opens a frame, and two more for the byte that closes it. The segment sequencer
// loads one segment a cycle into the result register while the result side has room. A
// two-word queue sits between the front end and the sequencer, so input words are
// taken while earlier ones are still being sent. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; unknown indices are ignored.
module pulse_width_ir_frame_encoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [irenc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [irenc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    irenc_in_if.sink                          in_ch,
    irenc_out_if.source                       out_ch
);
    import irenc_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    queue_port_t push;
    queue_port_t head;
    logic        queue_full;
    logic        pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIGH_ONE_TIME:  cfg_next.high_one_time  = cfg_wdata;
                REG_HIGH_ZERO_TIME: cfg_next.high_zero_time = cfg_wdata;
                REG_GAP_TIME:       cfg_next.gap_time       = cfg_wdata;
                REG_TAIL_TIME:      cfg_next.tail_time      = cfg_wdata;
                REG_LEAD_TIME:      cfg_next.lead_time      = cfg_wdata;
                REG_PREAMBLE_COUNT: cfg_next.preamble_count = cfg_wdata[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_one_time  <= RST_HIGH_ONE_TIME;
            cfg_reg.high_zero_time <= RST_HIGH_ZERO_TIME;
            cfg_reg.gap_time       <= RST_GAP_TIME;
            cfg_reg.tail_time      <= RST_TAIL_TIME;
            cfg_reg.lead_time      <= RST_LEAD_TIME;
            cfg_reg.preamble_count <= RST_PREAMBLE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    irenc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    irenc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

FILE: hdl/irenc_checker.sv
// Port-level checks for the pulse-width IR frame encoder result channel.
// Bound to pulse_width_ir_frame_encoder_core; no other dependencies.
module irenc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       level,
    input logic [7:0] duration,
    input logic       run_end,
    input logic       frame_done
);

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(duration)
            && $stable(run_end) && $stable(frame_done))
        else $error("Result word changed while stalled.");

    a_close_segment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_end && !level && (duration == 8'd0))
        else $error("Closing segment is not a zero-length low run end.");

    a_run_end_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level |-> !run_end && !frame_done)
        else $error("A high segment was marked as the end of a word.");

endmodule

bind pulse_width_ir_frame_encoder_core irenc_checker u_irenc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .level      (out_ch.level),
    .duration   (out_ch.duration),
    .run_end    (out_ch.run_end),
    .frame_done (out_ch.frame_done)
);

FILE: verif/tb_pulse_width_ir_frame_encoder_core.sv
// Testbench for pulse_width_ir_frame_encoder_core: sends byte words with random gaps and stalls,
// predicts every IR segment word in a small scoreboard class and checks them in order.
// Depends on irenc_pkg, the irenc_in_if and irenc_out_if interfaces and the encoder RTL.
module tb_pulse_width_ir_frame_encoder_core;
    import irenc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int END_CYCLES    = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 70;

    typedef struct packed {
        logic       level;
        logic [7:0] duration;
        logic       run_end;
        logic       frame_done;
    } segment_t;

    class ir_frame_tracker;
        cfg_t     regs;
        bit       in_frame;
        segment_t pending_segments[$];
        int       errors;
        int       checked;

        function new();
            regs.high_one_time  = RST_HIGH_ONE_TIME;
            regs.high_zero_time = RST_HIGH_ZERO_TIME;
            regs.gap_time       = RST_GAP_TIME;
            regs.tail_time      = RST_TAIL_TIME;
            regs.lead_time      = RST_LEAD_TIME;
            regs.preamble_count = RST_PREAMBLE_COUNT;
            in_frame = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
            case (index)
                REG_HIGH_ONE_TIME:  regs.high_one_time  = value;
                REG_HIGH_ZERO_TIME: regs.high_zero_time = value;
                REG_GAP_TIME:       regs.gap_time       = value;
                REG_TAIL_TIME:      regs.tail_time      = value;
                REG_LEAD_TIME:      regs.lead_time      = value;
                REG_PREAMBLE_COUNT: regs.preamble_count = value[3:0];
                default: ;
            endcase
        endfunction

        function void push_segment(input logic level, input logic [7:0] duration,
                                   input logic frame_done);
            segment_t seg;
            seg.level      = level;
            seg.duration   = duration;
            seg.run_end    = 1'b0;
            seg.frame_done = frame_done;
            pending_segments.push_back(seg);
        endfunction

        function void add_byte(input logic [7:0] data_byte, input logic last_byte);
            segment_t seg;
            int       i;
            if (!in_frame)
            begin
                push_segment(1'b0, regs.lead_time, 1'b0);
                for (i = 0; i < regs.preamble_count; i++)
                begin
                    push_segment(1'b1, regs.high_zero_time, 1'b0);
                    push_segment(1'b0, regs.gap_time, 1'b0);
                end
                push_segment(1'b1, regs.high_one_time, 1'b0);
                push_segment(1'b0, regs.gap_time, 1'b0);
                in_frame = 1'b1;
            end
            for (i = 0; i < 8; i++)
            begin
                push_segment(1'b1, data_byte[i] ? regs.high_one_time : regs.high_zero_time, 1'b0);
                push_segment(1'b0, regs.gap_time, 1'b0);
            end
            if (last_byte)
            begin
                push_segment(1'b1, regs.tail_time, 1'b0);
                push_segment(1'b0, 8'd0, 1'b1);
                in_frame = 1'b0;
            end
            seg = pending_segments.pop_back();
            seg.run_end = 1'b1;
            pending_segments.push_back(seg);
        endfunction

        task report_mismatch(input string msg);
            $display("%0t: segment %0d: %s", $time, checked, msg);
            errors++;
        endtask

        task check_segment(input logic level, input logic [7:0] duration,
                           input logic run_end, input logic frame_done);
            segment_t want;
            if (pending_segments.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word level=%0b duration=%0d",
                                          level, duration));
            end
            else
            begin
                want = pending_segments.pop_front();
                if (level !== want.level)
                    report_mismatch($sformatf("level %0b, wanted %0b", level, want.level));
                if (duration !== want.duration)
                    report_mismatch($sformatf("duration %0d, wanted %0d",
                                              duration, want.duration));
                if (run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %0b, wanted %0b", run_end, want.run_end));
                if (frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %0b, wanted %0b",
                                              frame_done, want.frame_done));
            end
            checked++;
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold;
    int quiet_cycles;

    ir_frame_tracker tracker = new();

    irenc_in_if  in_if();
    irenc_out_if out_if();

    pulse_width_ir_frame_encoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
                tracker.check_segment(out_if.level, out_if.duration, out_if.run_end,
                                      out_if.frame_done);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] data_byte, input logic last_byte);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= data_byte;
        in_if.last_byte <= last_byte;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        tracker.add_byte(data_byte, last_byte);
    endtask

    task automatic drain_segments();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (tracker.pending_segments.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        tracker.write_reg(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [7:0] one_time, input logic [7:0] zero_time,
                              input logic [7:0] gap, input logic [7:0] tail,
                              input logic [7:0] lead, input logic [7:0] preamble);
        write_reg(REG_HIGH_ONE_TIME, one_time);
        write_reg(REG_HIGH_ZERO_TIME, zero_time);
        write_reg(REG_GAP_TIME, gap);
        write_reg(REG_TAIL_TIME, tail);
        write_reg(REG_LEAD_TIME, lead);
        write_reg(REG_PREAMBLE_COUNT, preamble);
    endtask

    function automatic logic [7:0] pick_duration();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'd255;
        else if (roll < 20)
            return 8'd1;
        else if (roll < 23)
            return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_preamble();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return 8'h00;
        else if (roll < 30)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        int sent;
        int frame_len;
        int n;
        int phase;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_HIGH_ONE_TIME;
        cfg_wdata       = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        rx_hold         = 1'b0;
        quiet_cycles    = 0;
        tx_idle_pct     = 38;
        rx_idle_pct     = 55;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Values after reset, with a single-byte frame and a frame of three words.
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b1);
        drain_segments();

        set_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        drain_segments();

        // Shortest nonzero times and no preamble, so the start pulse follows the lead-in.
        set_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'h00);
        send_word(8'h01, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h7E, 1'b1);
        drain_segments();

        set_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00);
        send_word(8'hC3, 1'b1);
        send_word(8'h3C, 1'b0);
        drain_segments();

        // A write inside an open frame applies from the next word on.
        write_reg(REG_GAP_TIME, 8'd9);
        write_reg(REG_PREAMBLE_COUNT, 8'hF3);
        write_reg(REG_HIGH_ONE_TIME, 8'd200);
        send_word(8'h96, 1'b1);
        drain_segments();

        write_reg(REG_SPARE_6, 8'($urandom_range(255)));
        write_reg(REG_SPARE_7, 8'($urandom_range(255)));
        send_word(8'h55, 1'b1);
        send_word(8'hAA, 1'b1);
        drain_segments();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            tx_idle_pct = (phase < 2) ? 38 : ((phase < 4) ? 55 : 0);
            rx_idle_pct = (phase < 2) ? 55 : ((phase < 4) ? 38 : 0);
            set_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                       pick_duration(), pick_preamble());
            if (phase == 4)
            begin
                fork
                    begin
                        @(posedge clk);
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    frame_len = $urandom_range(1, 6);
                    for (n = 0; n < frame_len; n++)
                        send_word(8'($urandom_range(255)), n == frame_len - 1);
                    sent += frame_len;
                    if ($urandom_range(99) < 6)
                        drain_segments();
                end
                else
                begin
                    send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent++;
                end
            end
            drain_segments();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (tracker.pending_segments.size() != 0)
            tracker.report_mismatch($sformatf("%0d segment words never arrived",
                                              tracker.pending_segments.size()));
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
